// ===== hw/rtl/midi_key_scan_merger_defines.svh =====
// assertion macros shared by the midi key scan merger rtl
`ifndef MIDI_KEY_SCAN_MERGER_DEFINES_SVH
`define MIDI_KEY_SCAN_MERGER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MKM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("mkm assertion failed");

// next-cycle implication, disabled during reset
`define MKM_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("mkm assertion failed");

`endif

// ===== hw/rtl/mkm_pkg.sv =====
// types and constants of the midi key scan merger
package mkm_pkg;

    // switch groups
    localparam int GROUP_BITS      = 8;
    localparam int NUM_GROUPS      = 3;
    localparam int SCAN_BITS       = GROUP_BITS * NUM_GROUPS;
    localparam int GROUP_SHIFT     = $clog2(GROUP_BITS);
    localparam int SCAN_IDX_W      = $clog2(SCAN_BITS);
    localparam int GROUP_WIDTH_DEF = 8;

    // command queue
    localparam int QUEUE_DEPTH_DEF = 2;

    // input kinds
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_OVERRUN = 2'd1;
    localparam logic [1:0] KIND_SCAN    = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_VELOCITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_BASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THIRD_BASE  = 3'd4;

    // configuration reset values
    localparam logic [3:0] CHANNEL_RST     = 4'd7;
    localparam logic [6:0] ON_VELOCITY_RST = 7'd127;
    localparam logic [6:0] FIRST_BASE_RST  = 7'd60;
    localparam logic [6:0] SECOND_BASE_RST = 7'd68;
    localparam logic [6:0] THIRD_BASE_RST  = 7'd76;

    // midi codes
    localparam logic [3:0] NOTE_ON_NIBBLE  = 4'h9;
    localparam logic [3:0] NOTE_OFF_NIBBLE = 4'h8;
    localparam logic [7:0] REALTIME_MIN    = 8'hF8;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
        logic [7:0] first_levels;
        logic [7:0] second_levels;
        logic [7:0] third_levels;
    } in_item_t;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] data_first;
        logic [6:0] data_second;
        logic       from_remote;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [3:0] channel;
        logic [6:0] on_velocity;
        logic [6:0] first_group_base;
        logic [6:0] second_group_base;
        logic [6:0] third_group_base;
    } cfg_t;

    // work handed from front to back
    typedef struct packed {
        logic                 remote;
        logic [7:0]           status_byte;
        logic [6:0]           data_first;
        logic [6:0]           data_second;
        logic [SCAN_BITS-1:0] mask;
        logic [SCAN_BITS-1:0] levels;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== hw/rtl/mkm_front.sv =====
// front end: midi byte assembler and switch change detection
module mkm_front #(
    parameter int GROUP_WIDTH = mkm_pkg::GROUP_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  mkm_pkg::in_item_t  in_data,
    input  mkm_pkg::q_status_t q_status,
    output logic               push,
    output mkm_pkg::cmd_t      push_cmd
);
    import mkm_pkg::*;

    typedef enum logic [2:0] {
        PH_STATUS = 3'b001,
        PH_DATA1  = 3'b010,
        PH_DATA2  = 3'b100
    } phase_t;

    localparam logic [GROUP_BITS-1:0] GROUP_MASK = GROUP_BITS'((1 << GROUP_WIDTH) - 1);
    localparam logic [SCAN_BITS-1:0]  SCAN_MASK  = {NUM_GROUPS{GROUP_MASK}};

    phase_t               phase_reg, phase_next;
    logic [SCAN_BITS-1:0] prev_levels_reg, prev_levels_next;
    logic [7:0]           held_status_reg, held_status_next;
    logic [6:0]           held_first_reg, held_first_next;
    logic                 accept;
    logic [SCAN_BITS-1:0] cur_levels;
    logic [SCAN_BITS-1:0] scan_mask;

    assign in_stall   = q_status.full;
    assign accept     = in_valid && !q_status.full;
    assign cur_levels = {in_data.third_levels, in_data.second_levels, in_data.first_levels};
    assign scan_mask  = (cur_levels ^ prev_levels_reg) & SCAN_MASK;

    always_comb
    begin
        phase_next       = phase_reg;
        prev_levels_next = prev_levels_reg;
        held_status_next = held_status_reg;
        held_first_next  = held_first_reg;
        push             = 1'b0;
        if (accept)
        begin
            case (in_data.kind)
                KIND_BYTE:
                begin
                    if (in_data.rx_byte >= REALTIME_MIN)
                    begin
                        // real-time byte, ignored
                    end
                    else if (in_data.rx_byte[7])
                    begin
                        held_status_next = in_data.rx_byte;
                        phase_next       = PH_DATA1;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_DATA1:
                            begin
                                held_first_next = in_data.rx_byte[6:0];
                                phase_next      = PH_DATA2;
                            end
                            PH_DATA2:
                            begin
                                phase_next = PH_STATUS;
                                push       = 1'b1;
                            end
                            default: phase_next = PH_STATUS;
                        endcase
                    end
                end
                KIND_OVERRUN: phase_next = PH_STATUS;
                KIND_SCAN:
                begin
                    prev_levels_next = cur_levels;
                    push             = (scan_mask != '0);
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        push_cmd.remote      = (in_data.kind == KIND_BYTE);
        push_cmd.status_byte = held_status_reg;
        push_cmd.data_first  = held_first_reg;
        push_cmd.data_second = in_data.rx_byte[6:0];
        push_cmd.mask        = scan_mask;
        push_cmd.levels      = cur_levels;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_STATUS;
            prev_levels_reg <= '1;
        end
        else
        begin
            phase_reg       <= phase_next;
            prev_levels_reg <= prev_levels_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_status_reg <= held_status_next;
        held_first_reg  <= held_first_next;
    end

endmodule

// ===== hw/rtl/mkm_queue.sv =====
// command queue between front and back
`include "midi_key_scan_merger_defines.svh"
module mkm_queue #(
    parameter int DEPTH = mkm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mkm_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output mkm_pkg::cmd_t      pop_cmd,
    output mkm_pkg::q_status_t status
);
    import mkm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_cmd      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `MKM_ASSERT_IMP(a_no_push_when_full, clk, rst_n, push, !status.full)
    `MKM_ASSERT_IMP(a_no_pop_when_empty, clk, rst_n, pop, !status.empty)
    `MKM_ASSERT_IMP(a_count_in_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))

endmodule

// ===== hw/rtl/mkm_back.sv =====
// back end: expands queued commands into midi messages, one per cycle while the output is not stalled
`include "midi_key_scan_merger_defines.svh"
module mkm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mkm_pkg::cfg_t      cfg,
    input  mkm_pkg::cmd_t      q_cmd,
    input  mkm_pkg::q_status_t q_status,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output mkm_pkg::out_item_t out_data
);
    import mkm_pkg::*;

    localparam logic [1:0] GRP_FIRST  = 2'd0;
    localparam logic [1:0] GRP_SECOND = 2'd1;

    logic                   job_valid_reg, job_valid_next;
    cmd_t                   job_reg, job_next;
    logic [SCAN_BITS-1:0]   mask_reg, mask_next;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_reg, out_next;

    logic                   advance;
    logic                   done;
    logic [SCAN_BITS-1:0]   lsb;
    logic [SCAN_BITS-1:0]   rest;
    logic [SCAN_IDX_W-1:0]  idx;
    logic [GROUP_SHIFT-1:0] bit_idx;
    logic [1:0]             grp;
    logic [6:0]             base;
    logic                   level;
    out_item_t              msg;

    assign advance   = job_valid_reg && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // lowest pending change
    always_comb
    begin
        lsb  = mask_reg & (~mask_reg + SCAN_BITS'(1));
        rest = mask_reg & ~lsb;
        idx  = '0;
        for (int i = 0; i < SCAN_BITS; i++)
        begin
            if (lsb[i])
            begin
                idx = idx | SCAN_IDX_W'(i);
            end
        end
        bit_idx = idx[GROUP_SHIFT-1:0];
        grp     = 2'(idx >> GROUP_SHIFT);
        case (grp)
            GRP_FIRST:  base = cfg.first_group_base;
            GRP_SECOND: base = cfg.second_group_base;
            default:    base = cfg.third_group_base;
        endcase
        level = job_reg.levels[idx];
    end

    always_comb
    begin
        if (job_reg.remote)
        begin
            msg.status_byte = job_reg.status_byte;
            msg.data_first  = job_reg.data_first;
            msg.data_second = job_reg.data_second;
            msg.from_remote = 1'b1;
            msg.last        = 1'b1;
        end
        else
        begin
            msg.status_byte = level ? {NOTE_OFF_NIBBLE, cfg.channel}
                                    : {NOTE_ON_NIBBLE, cfg.channel};
            msg.data_first  = base + 7'(bit_idx);
            msg.data_second = level ? 7'd0 : cfg.on_velocity;
            msg.from_remote = 1'b0;
            msg.last        = (rest == '0);
        end
        done = msg.last;
    end

    always_comb
    begin
        pop            = !q_status.empty && (!job_valid_reg || (advance && done));
        job_valid_next = job_valid_reg;
        job_next       = job_reg;
        mask_next      = mask_reg;
        if (pop)
        begin
            job_valid_next = 1'b1;
            job_next       = q_cmd;
            mask_next      = q_cmd.mask;
        end
        else if (advance)
        begin
            job_valid_next = !done;
            mask_next      = rest;
        end
        out_valid_next = advance || (out_valid_reg && out_stall);
        out_next       = advance ? msg : out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        mask_reg <= mask_next;
        out_reg  <= out_next;
    end

    `MKM_ASSERT_IMP(a_scan_job_has_work, clk, rst_n, job_valid_reg && !job_reg.remote,
                    mask_reg != '0)
    `MKM_ASSERT_NXT(a_advance_fills_out, clk, rst_n, advance, out_valid_reg)
    `MKM_ASSERT_IMP(a_pop_only_when_free, clk, rst_n, pop,
                    !job_valid_reg || (advance && done))

endmodule

// ===== hw/rtl/midi_key_scan_merger.sv =====
// an item's result is registered in the command queue, then the back end's job register, then the output register
// a scan tick with n switch changes gives n messages from the back end, one per cycle unless stalled
// a received byte or overrun is taken as one item; a two-entry command queue decouples the sides
// input stalls only while the command queue is full; output register holds a message under stall
// reset (rst_n, async, active low): config to defaults, assembler waits for status,
// stored switch levels all released, queue and output empty
module midi_key_scan_merger #(
    parameter int GROUP_WIDTH = mkm_pkg::GROUP_WIDTH_DEF,
    parameter int QUEUE_DEPTH = mkm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // item channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  mkm_pkg::in_item_t                in_data,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output mkm_pkg::out_item_t               out_data,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mkm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mkm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mkm_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      push;
    logic      pop;
    cmd_t      push_cmd;
    cmd_t      pop_cmd;
    q_status_t q_status;

    // config writes are always taken, cfg_ready is tied high
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CHANNEL:     cfg_next.channel           = cfg_data[3:0];
                CFG_ON_VELOCITY: cfg_next.on_velocity       = cfg_data[6:0];
                CFG_FIRST_BASE:  cfg_next.first_group_base  = cfg_data[6:0];
                CFG_SECOND_BASE: cfg_next.second_group_base = cfg_data[6:0];
                CFG_THIRD_BASE:  cfg_next.third_group_base  = cfg_data[6:0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel           <= CHANNEL_RST;
            cfg_reg.on_velocity       <= ON_VELOCITY_RST;
            cfg_reg.first_group_base  <= FIRST_BASE_RST;
            cfg_reg.second_group_base <= SECOND_BASE_RST;
            cfg_reg.third_group_base  <= THIRD_BASE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: assembles remote messages, detects switch changes
    mkm_front #(
        .GROUP_WIDTH (GROUP_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // command queue between the two sides
    mkm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    // back: one message per cycle into the output register while the output is not stalled
    mkm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_cmd     (pop_cmd),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== bench/tb_top.sv =====
// self-checking testbench for the midi key scan merger
`timescale 1ns / 100ps

module tb_top;

    import mkm_pkg::*;

    // scanned bits per group, handed to the block so both sides agree
    localparam int GROUP_WIDTH = 8;
    // kind code that the block has no use for
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // receiver hold-off while the sender keeps offering scan ticks
    localparam int HOLD_CYCLES = 400;
    // drain time after the last expected message, well beyond the block's latency
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_SHOWN = 10;

    // assembler phases of the remote byte stream
    typedef enum logic [1:0] {PH_STATUS, PH_DATA1, PH_DATA2} asm_phase_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predicted state of the block
    cfg_t live_cfg;
    asm_phase_t asm_phase;
    logic [7:0] held_status;
    logic [6:0] held_data;
    logic [SCAN_BITS-1:0] switch_levels;

    // messages predicted but not yet seen on the output
    out_item_t pending_msgs[$];

    int errors;
    int items_sent;
    int cycle_count;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_requests;
    int holds_served;

    midi_key_scan_merger #(
        .GROUP_WIDTH(GROUP_WIDTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit, counted in clock cycles
    initial
    begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // receiver side: random stall, plus a long hold-off whenever one is requested
    initial
    begin
        out_stall = 1'b0;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                repeat (HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // works out the messages one accepted item causes and advances the predicted state
    function automatic void predict_messages(input in_item_t it);
        out_item_t msg;
        logic [7:0] lv [3];
        logic [6:0] base [3];
        logic [7:0] changed;
        int total;
        int n;
        lv[0] = it.first_levels;
        lv[1] = it.second_levels;
        lv[2] = it.third_levels;
        base[0] = live_cfg.first_group_base;
        base[1] = live_cfg.second_group_base;
        base[2] = live_cfg.third_group_base;
        case (it.kind)
            KIND_BYTE:
            begin
                if (it.rx_byte >= REALTIME_MIN)
                begin
                    // real-time bytes pass by the assembler untouched
                end
                else if (it.rx_byte[7])
                begin
                    // a status byte always (re)starts a message
                    held_status = it.rx_byte;
                    asm_phase = PH_DATA1;
                end
                else if (asm_phase == PH_DATA1)
                begin
                    held_data = it.rx_byte[6:0];
                    asm_phase = PH_DATA2;
                end
                else if (asm_phase == PH_DATA2)
                begin
                    msg.status_byte = held_status;
                    msg.data_first = held_data;
                    msg.data_second = it.rx_byte[6:0];
                    msg.from_remote = 1'b1;
                    msg.last = 1'b1;
                    pending_msgs.push_back(msg);
                    asm_phase = PH_STATUS;
                end
                else
                begin
                    // stray data byte is dropped
                    asm_phase = PH_STATUS;
                end
            end
            KIND_OVERRUN:
                asm_phase = PH_STATUS;
            KIND_SCAN:
            begin
                // count first so the final message can carry last
                total = 0;
                for (int g = 0; g < NUM_GROUPS; g++)
                begin
                    changed = lv[g] ^ switch_levels[g*GROUP_BITS +: GROUP_BITS];
                    for (int i = 0; i < GROUP_WIDTH && i < GROUP_BITS; i++)
                        total += changed[i];
                end
                n = 0;
                for (int g = 0; g < NUM_GROUPS; g++)
                begin
                    changed = lv[g] ^ switch_levels[g*GROUP_BITS +: GROUP_BITS];
                    for (int i = 0; i < GROUP_WIDTH && i < GROUP_BITS; i++)
                    begin
                        if (changed[i])
                        begin
                            n++;
                            // active low: a low level is a pressed switch
                            msg.status_byte = {lv[g][i] ? NOTE_OFF_NIBBLE : NOTE_ON_NIBBLE,
                                               live_cfg.channel};
                            msg.data_first = base[g] + 7'(i);
                            msg.data_second = lv[g][i] ? 7'd0 : live_cfg.on_velocity;
                            msg.from_remote = 1'b0;
                            msg.last = (n == total);
                            pending_msgs.push_back(msg);
                        end
                    end
                    // all eight bits are stored, scanned or not
                    switch_levels[g*GROUP_BITS +: GROUP_BITS] = lv[g];
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // every result transfer is checked against the oldest prediction
    always @(posedge clk)
    begin : check_messages
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_msgs.size() == 0)
            begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected message: st=%h d1=%h d2=%h remote=%b last=%b",
                             out_data.status_byte, out_data.data_first,
                             out_data.data_second, out_data.from_remote, out_data.last);
            end
            else
            begin
                want = pending_msgs.pop_front();
                if (out_data.status_byte !== want.status_byte ||
                    out_data.data_first !== want.data_first ||
                    out_data.data_second !== want.data_second ||
                    out_data.from_remote !== want.from_remote ||
                    out_data.last !== want.last)
                begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("message mismatch: expected st=%h d1=%h d2=%h r=%b l=%b, %s",
                                 want.status_byte, want.data_first, want.data_second,
                                 want.from_remote, want.last,
                                 $sformatf("got st=%h d1=%h d2=%h r=%b l=%b",
                                           out_data.status_byte, out_data.data_first,
                                           out_data.data_second, out_data.from_remote,
                                           out_data.last));
                end
            end
        end
    end

    // item with random content in every field, the kind aside
    function automatic in_item_t rand_item(input logic [1:0] k);
        in_item_t it;
        it.kind = k;
        it.rx_byte = 8'($urandom);
        it.first_levels = 8'($urandom);
        it.second_levels = 8'($urandom);
        it.third_levels = 8'($urandom);
        return it;
    endfunction

    // one input transfer, with an optional idle gap before it; valid stays up afterwards
    task automatic send_item(input in_item_t it);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_messages(it);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        in_item_t it;
        it = rand_item(KIND_BYTE);
        it.rx_byte = b;
        send_item(it);
    endtask

    task automatic send_scan(input logic [SCAN_BITS-1:0] lv);
        in_item_t it;
        it = rand_item(KIND_SCAN);
        it.first_levels = lv[7:0];
        it.second_levels = lv[15:8];
        it.third_levels = lv[23:16];
        send_item(it);
    endtask

    // lets every predicted message out, then the latency on top for silent items
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_msgs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // cfg_valid is left high between back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_CHANNEL: live_cfg.channel = val[3:0];
            CFG_ON_VELOCITY: live_cfg.on_velocity = val;
            CFG_FIRST_BASE: live_cfg.first_group_base = val;
            CFG_SECOND_BASE: live_cfg.second_group_base = val;
            CFG_THIRD_BASE: live_cfg.third_group_base = val;
            default:
            begin
            end
        endcase
    endtask

    task automatic load_settings(input logic [3:0] ch, input logic [6:0] vel,
                                 input logic [6:0] b1, input logic [6:0] b2,
                                 input logic [6:0] b3);
        wait_idle();
        write_reg(CFG_CHANNEL, CFG_DATA_W'(ch));
        write_reg(CFG_ON_VELOCITY, vel);
        write_reg(CFG_FIRST_BASE, b1);
        write_reg(CFG_SECOND_BASE, b2);
        write_reg(CFG_THIRD_BASE, b3);
        cfg_valid <= 1'b0;
    endtask

    // field extremes, every kind and each corner of the assembler, reset settings
    task automatic test_directed_traffic();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        send_byte(8'h12);               // stray data while waiting for status
        send_byte(8'h90);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'hF7);               // highest status byte that is not real-time
        send_byte(8'hF8);               // real-time inside a message
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h10);
        send_byte(8'hB0);               // early status restarts the message
        send_byte(8'h20);
        send_byte(8'h30);
        send_byte(8'hC5);
        send_byte(8'h11);
        send_item(rand_item(KIND_OVERRUN));
        send_byte(8'h22);               // dropped, overrun sent the assembler back
        send_item(rand_item(KIND_UNUSED));
        send_scan('0);                  // every switch pressed
        send_scan('1);                  // every switch released
        send_scan(24'h7FFFFE);          // lowest and highest bit
        send_scan('1);
        wait_idle();
    endtask

    // register extremes, including bases whose upper notes wrap past 127
    task automatic test_register_extremes();
        load_settings(4'd15, 7'd0, 7'd127, 7'd121, 7'd0);
        send_scan('0);
        send_scan('1);
        send_byte(8'hE3);
        send_byte(8'h01);
        send_byte(8'h7E);
        load_settings(4'd0, 7'd127, 7'd120, 7'd0, 7'd120);
        send_scan('0);
        send_scan(24'hA5A5A5);
        send_scan('1);
        wait_idle();
    endtask

    // receiver holds off while full scans keep coming, so the input side must stall
    task automatic test_backpressure();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_requests++;
        for (int k = 0; k < 10; k++)
        begin
            send_scan((k % 2 == 0) ? '0 : '1);
            if (k == 4)
            begin
                send_byte(8'h9A);
                send_byte(8'h45);
                send_byte(8'h33);
            end
        end
        wait_idle();
    endtask

    // one random sequence: mostly well-formed messages and scans, some noise
    task automatic random_burst();
        int pick;
        logic [SCAN_BITS-1:0] flips;
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            send_byte(8'($urandom_range(8'hF7, 8'h80)));
            for (int d = 0; d < 2; d++)
            begin
                if ($urandom_range(99) < 15)
                    send_byte(8'($urandom_range(8'hFF, 8'hF8)));
                send_byte(8'($urandom_range(127)));
            end
        end
        else if (pick < 75)
        begin
            // mostly a few switches move, now and then a whole new pattern
            if ($urandom_range(99) < 15)
                flips = 24'($urandom);
            else
            begin
                flips = '0;
                for (int b = 0; b < SCAN_BITS; b++)
                    flips[b] = ($urandom_range(7) == 0);
            end
            send_scan(switch_levels ^ flips);
        end
        else
        begin
            case ($urandom_range(5))
                0: send_byte(8'($urandom_range(127)));
                1: send_item(rand_item(KIND_OVERRUN));
                2:
                begin
                    send_byte(8'($urandom_range(8'hF7, 8'h80)));
                    send_byte(8'($urandom_range(127)));
                    send_byte(8'($urandom_range(8'hF7, 8'h80)));
                    send_byte(8'($urandom_range(127)));
                    send_byte(8'($urandom_range(127)));
                end
                3: send_item(rand_item(KIND_UNUSED));
                4: send_byte(8'($urandom_range(8'hFF, 8'hF8)));
                default:
                begin
                    // message broken by an overrun
                    send_byte(8'($urandom_range(8'hF7, 8'h80)));
                    send_byte(8'($urandom_range(127)));
                    send_item(rand_item(KIND_OVERRUN));
                    send_byte(8'($urandom_range(127)));
                end
            endcase
        end
    endtask

    // random traffic under fresh random settings and the given idling
    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
        int start;
        load_settings(4'($urandom_range(15)), 7'($urandom_range(127)),
                      7'($urandom_range(120)), 7'($urandom_range(120)),
                      7'($urandom_range(120)));
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        start = items_sent;
        while (items_sent - start < count)
            random_burst();
        wait_idle();
    endtask

    initial
    begin
        errors = 0;
        items_sent = 0;
        hold_requests = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        // predicted state after reset
        live_cfg.channel = CHANNEL_RST;
        live_cfg.on_velocity = ON_VELOCITY_RST;
        live_cfg.first_group_base = FIRST_BASE_RST;
        live_cfg.second_group_base = SECOND_BASE_RST;
        live_cfg.third_group_base = THIRD_BASE_RST;
        asm_phase = PH_STATUS;
        held_status = '0;
        held_data = '0;
        switch_levels = '1;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_traffic();
        test_register_extremes();
        test_backpressure();
        test_random_traffic(0, 0, 55);
        test_random_traffic(72, 0, 55);
        test_random_traffic(0, 72, 55);
        test_random_traffic(23, 23, 55);

        // wait_idle above has already drained everything; anything left is lost
        if (pending_msgs.size() != 0)
        begin
            errors++;
            $display("missing messages: %0d", pending_msgs.size());
        end
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mkm_pkg.sv
hw/rtl/mkm_front.sv
hw/rtl/mkm_queue.sv
hw/rtl/mkm_back.sv
hw/rtl/midi_key_scan_merger.sv
bench/tb_top.sv
